// ----- sv/bflm_pkg.sv -----
// bflm_pkg: shared types, codes and constants of the battery fault latch monitor
`timescale 1ns / 1ps

package bflm_pkg;

	// fixed sizing of the monitored pack
	localparam logic [3:0] NUM_DEVICES      = 4'd6;
	localparam logic [5:0] CELLS_PER_DEVICE = 6'd18;
	localparam logic [7:0] TEMP_WINDOW      = 8'd210;
	localparam logic [2:0] CURRENT_SAMPLES  = 3'd5;
	localparam logic [2:0] UV_EXEMPT_DEVICE = 3'd3;
	localparam logic [9:0] DISCONNECT_BELOW = 10'd5;
	localparam logic [6:0] CLEAN_CELLS_MAX  = 7'd127;

	// derived positions
	localparam logic [2:0] LAST_DEVICE = 3'(NUM_DEVICES - 4'd1);

	// request codes
	localparam logic [2:0] REQ_CELL_CODE     = 3'd0;
	localparam logic [2:0] REQ_SCAN_END      = 3'd1;
	localparam logic [2:0] REQ_THERMISTOR    = 3'd2;
	localparam logic [2:0] REQ_CURRENT_SAMPLE = 3'd3;
	localparam logic [2:0] REQ_CURRENT_CHECK = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_OVER_VOLTAGE  = 3'd0;
	localparam logic [2:0] REG_UNDER_VOLTAGE = 3'd1;
	localparam logic [2:0] REG_TEMP_HIGH     = 3'd2;
	localparam logic [2:0] REG_TEMP_LOW      = 3'd3;
	localparam logic [2:0] REG_CLEAN_NEEDED  = 3'd4;
	localparam logic [2:0] REG_TEMP_CLEAR    = 3'd5;
	localparam logic [2:0] REG_CURRENT_HIGH  = 3'd6;
	localparam logic [2:0] REG_CURRENT_LOW   = 3'd7;

	// configuration reset values
	localparam logic [15:0] OVER_VOLTAGE_RESET  = 16'd46000;
	localparam logic [15:0] UNDER_VOLTAGE_RESET = 16'd25000;
	localparam logic [7:0]  TEMP_HIGH_RESET     = 8'd45;
	localparam logic [7:0]  TEMP_LOW_RESET      = 8'd20;
	localparam logic [6:0]  CLEAN_NEEDED_RESET  = 7'd106;
	localparam logic [7:0]  TEMP_CLEAR_RESET    = 8'd200;
	localparam logic [12:0] CURRENT_HIGH_RESET  = 13'd4493;
	localparam logic [12:0] CURRENT_LOW_RESET   = 13'd1297;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [2:0]  device_index;
		logic [4:0]  cell_index;
		logic [15:0] cell_code;
		logic [7:0]  probe_shared;
		logic [7:0]  probe_low_side;
		logic [7:0]  probe_high_side;
		logic [9:0]  current_adc;
	} item_t;

	typedef struct packed {
		logic shutdown;
		logic voltage_fault;
		logic temperature_fault;
		logic current_fault;
		logic sensor_disconnected;
	} result_t;

	typedef struct packed {
		logic [15:0] over_voltage_limit;
		logic [15:0] under_voltage_limit;
		logic [7:0]  temp_high_limit;
		logic [7:0]  temp_low_limit;
		logic [6:0]  clean_cells_needed;
		logic [7:0]  temp_clear_run;
		logic [12:0] current_sum_high;
		logic [12:0] current_sum_low;
	} cfg_t;

	typedef struct packed {
		logic        volt_flag;
		logic        temp_flag;
		logic        curr_flag;
		logic        disc_flag;
		logic [6:0]  clean_cells;
		logic [7:0]  clean_msgs;
		logic [7:0]  msg_window;
		logic [12:0] adc_sum;
		logic [2:0]  adc_count;
	} state_t;

endpackage

// ----- sv/bflm_step.sv -----
// bflm_step: next fault state and result for one accepted transaction
`timescale 1ns / 1ps

module bflm_step #(
	parameter logic [3:0] NUM_DEVICES      = bflm_pkg::NUM_DEVICES,
	parameter logic [5:0] CELLS_PER_DEVICE = bflm_pkg::CELLS_PER_DEVICE,
	parameter logic [7:0] TEMP_WINDOW      = bflm_pkg::TEMP_WINDOW,
	parameter logic [2:0] CURRENT_SAMPLES  = bflm_pkg::CURRENT_SAMPLES
) (
	input  bflm_pkg::cfg_t    cfg,
	input  bflm_pkg::state_t  st,
	input  bflm_pkg::item_t   item,
	output bflm_pkg::state_t  st_next,
	output bflm_pkg::result_t res
);

	// derived positions
	localparam logic [2:0] LAST_DEVICE = 3'(NUM_DEVICES - 4'd1);

	logic [5:0]  cell_plus2;
	logic        cell_in_range;
	logic        uv_checked;
	logic        cell_fault;
	logic        probe_bad;
	logic [7:0]  window_inc;
	logic [12:0] sum_inc;

	// cell position rules
	always_comb begin
		cell_plus2    = {1'b0, item.cell_index} + 6'd2;
		cell_in_range = ({1'b0, item.device_index} < NUM_DEVICES) &&
			({1'b0, item.cell_index} < CELLS_PER_DEVICE);
		if (item.device_index == LAST_DEVICE) begin
			// only the lower cells of the last device are wired
			cell_in_range = cell_in_range && (cell_plus2 < CELLS_PER_DEVICE);
			uv_checked    = 1'b1;
		end else begin
			uv_checked = (item.device_index != bflm_pkg::UV_EXEMPT_DEVICE) &&
				(cell_plus2 < CELLS_PER_DEVICE);
		end
		cell_fault = (uv_checked && (item.cell_code < cfg.under_voltage_limit)) ||
			(item.cell_code > cfg.over_voltage_limit);
	end

	// thermistor and current helpers
	assign probe_bad = (item.probe_low_side < cfg.temp_low_limit) ||
		(item.probe_shared < cfg.temp_low_limit) ||
		(item.probe_high_side > cfg.temp_high_limit) ||
		(item.probe_shared > cfg.temp_high_limit);
	assign window_inc = st.msg_window + 8'd1;
	assign sum_inc    = st.adc_sum + {3'b000, item.current_adc};

	// state update by request type
	always_comb begin
		st_next = st;
		case (item.req_type)
			bflm_pkg::REQ_CELL_CODE: begin
				if (cell_in_range) begin
					if (cell_fault) begin
						st_next.volt_flag = 1'b1;
					end else if (st.clean_cells != bflm_pkg::CLEAN_CELLS_MAX) begin
						st_next.clean_cells = st.clean_cells + 7'd1;
					end
				end
			end
			bflm_pkg::REQ_SCAN_END: begin
				if (st.clean_cells == cfg.clean_cells_needed) begin
					st_next.volt_flag = 1'b0;
				end
				st_next.clean_cells = 7'd0;
			end
			bflm_pkg::REQ_THERMISTOR: begin
				st_next.msg_window = window_inc;
				if (probe_bad) begin
					st_next.temp_flag  = 1'b1;
					st_next.clean_msgs = 8'd0;
					st_next.msg_window = 8'd0;
				end else begin
					st_next.clean_msgs = st.clean_msgs + 8'd1;
				end
				if (st_next.clean_msgs == cfg.temp_clear_run) begin
					st_next.temp_flag = 1'b0;
				end
				// window restart
				if (st_next.msg_window == TEMP_WINDOW) begin
					st_next.clean_msgs = 8'd0;
					st_next.msg_window = 8'd0;
				end
			end
			bflm_pkg::REQ_CURRENT_SAMPLE: begin
				if (st.adc_count < CURRENT_SAMPLES) begin
					st_next.adc_sum   = sum_inc;
					st_next.adc_count = st.adc_count + 3'd1;
				end
			end
			bflm_pkg::REQ_CURRENT_CHECK: begin
				if (item.current_adc < bflm_pkg::DISCONNECT_BELOW) begin
					st_next.disc_flag = 1'b1;
					st_next.curr_flag = 1'b1;
				end else begin
					st_next.disc_flag = 1'b0;
					st_next.curr_flag = (st.adc_sum > cfg.current_sum_high) ||
						(st.adc_sum < cfg.current_sum_low);
				end
				st_next.adc_sum   = 13'd0;
				st_next.adc_count = 3'd0;
			end
			default: begin
				st_next = st;
			end
		endcase
	end

	// flags after the transaction
	always_comb begin
		res.shutdown            = st_next.volt_flag || st_next.temp_flag || st_next.curr_flag;
		res.voltage_fault       = st_next.volt_flag;
		res.temperature_fault   = st_next.temp_flag;
		res.current_fault       = st_next.curr_flag;
		res.sensor_disconnected = st_next.disc_flag;
	end

endmodule

// ----- sv/battery_fault_latch_monitor_core.sv -----
// battery_fault_latch_monitor_core: top level with config registers, fault state and output skid
`timescale 1ns / 1ps

// channel  | signals                        | moves
// ---------+--------------------------------+-----------------------------------
// item     | item_valid, item_stall, item   | one request transaction in
// result   | result_valid, result_stall,    | fault flags after each request
//          | result                         |
// config   | cfg_write, cfg_index, cfg_data | one register write, no read-back
//
// One transaction is taken every cycle while item_stall is low; its result is registered into
// the result register, or into the skid while the result register holds a waiting result.
// Reset clears all fault state and loads the default limits; no clearing pass is needed.
// A two-entry output buffer (result register plus skid) lets input run while result stalls;
// item_stall rises only once both entries hold a waiting result.

module battery_fault_latch_monitor_core #(
	parameter logic [3:0] NUM_DEVICES      = bflm_pkg::NUM_DEVICES,
	parameter logic [5:0] CELLS_PER_DEVICE = bflm_pkg::CELLS_PER_DEVICE,
	parameter logic [7:0] TEMP_WINDOW      = bflm_pkg::TEMP_WINDOW,
	parameter logic [2:0] CURRENT_SAMPLES  = bflm_pkg::CURRENT_SAMPLES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  bflm_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output bflm_pkg::result_t   result,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	bflm_pkg::cfg_t    cfg_q;
	bflm_pkg::state_t  state_q;
	bflm_pkg::state_t  state_next;
	bflm_pkg::result_t step_res;
	bflm_pkg::result_t out_q;
	bflm_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              item_take;
	logic              result_take;

	assign item_stall   = skid_valid_q;
	assign item_take    = item_valid && !skid_valid_q;
	assign result_take  = out_valid_q && !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.over_voltage_limit  <= bflm_pkg::OVER_VOLTAGE_RESET;
			cfg_q.under_voltage_limit <= bflm_pkg::UNDER_VOLTAGE_RESET;
			cfg_q.temp_high_limit     <= bflm_pkg::TEMP_HIGH_RESET;
			cfg_q.temp_low_limit      <= bflm_pkg::TEMP_LOW_RESET;
			cfg_q.clean_cells_needed  <= bflm_pkg::CLEAN_NEEDED_RESET;
			cfg_q.temp_clear_run      <= bflm_pkg::TEMP_CLEAR_RESET;
			cfg_q.current_sum_high    <= bflm_pkg::CURRENT_HIGH_RESET;
			cfg_q.current_sum_low     <= bflm_pkg::CURRENT_LOW_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				bflm_pkg::REG_OVER_VOLTAGE:  cfg_q.over_voltage_limit  <= cfg_data;
				bflm_pkg::REG_UNDER_VOLTAGE: cfg_q.under_voltage_limit <= cfg_data;
				bflm_pkg::REG_TEMP_HIGH:     cfg_q.temp_high_limit     <= cfg_data[7:0];
				bflm_pkg::REG_TEMP_LOW:      cfg_q.temp_low_limit      <= cfg_data[7:0];
				bflm_pkg::REG_CLEAN_NEEDED:  cfg_q.clean_cells_needed  <= cfg_data[6:0];
				bflm_pkg::REG_TEMP_CLEAR:    cfg_q.temp_clear_run      <= cfg_data[7:0];
				bflm_pkg::REG_CURRENT_HIGH:  cfg_q.current_sum_high    <= cfg_data[12:0];
				bflm_pkg::REG_CURRENT_LOW:   cfg_q.current_sum_low     <= cfg_data[12:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// next state and result of the offered transaction
	bflm_step #(
		.NUM_DEVICES      (NUM_DEVICES),
		.CELLS_PER_DEVICE (CELLS_PER_DEVICE),
		.TEMP_WINDOW      (TEMP_WINDOW),
		.CURRENT_SAMPLES  (CURRENT_SAMPLES)
	) u_step (
		.cfg     (cfg_q),
		.st      (state_q),
		.item    (item),
		.st_next (state_next),
		.res     (step_res)
	);

	// fault state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (item_take) begin
			state_q <= state_next;
		end
	end

	// output buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (result_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= item_take;
				end
			end else if (item_take) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (result_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (item_take) begin
				out_q <= step_res;
			end
		end else if (item_take) begin
			if (out_valid_q) begin
				skid_q <= step_res;
			end else begin
				out_q <= step_res;
			end
		end
	end

endmodule
